// ===== rtl/rde_pkg.sv =====
package rde_pkg;

	// Default width of the value to convert
	localparam int unsigned VALUE_WIDTH_DEF = 16;

	// Register and field widths
	localparam int unsigned RADIX_W = 5;
	localparam int unsigned DIGIT_W = 4;
	localparam int unsigned CHAR_W  = 7;

	// Radix limits and reset value
	localparam logic [RADIX_W-1:0] RADIX_RESET = 5'd10;
	localparam logic [RADIX_W-1:0] RADIX_MIN   = 5'd2;
	localparam logic [RADIX_W-1:0] RADIX_MAX   = 5'd16;

	// Character codes
	localparam logic [CHAR_W-1:0] CHAR_NEWLINE = 7'd10;
	localparam logic [CHAR_W-1:0] CHAR_ZERO    = 7'd48;
	localparam logic [CHAR_W-1:0] CHAR_ALPHA   = 7'd65;
	localparam logic [DIGIT_W-1:0] DIGIT_TEN   = 4'd10;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIV,
		ST_EMIT,
		ST_NEWLINE
	} state_t;

	// Map a remainder to its ASCII digit
	function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d);
		logic [CHAR_W-1:0] c;
		if (d < DIGIT_TEN) begin
			c = CHAR_ZERO + CHAR_W'(d);
		end else begin
			c = CHAR_ALPHA + CHAR_W'(d - DIGIT_TEN);
		end
		return c;
	endfunction

	// Clamp the radix register to the supported bases
	function automatic logic [RADIX_W-1:0] clamp_radix(input logic [RADIX_W-1:0] r);
		logic [RADIX_W-1:0] b;
		if (r < RADIX_MIN) begin
			b = RADIX_MIN;
		end else if (r > RADIX_MAX) begin
			b = RADIX_MAX;
		end else begin
			b = r;
		end
		return b;
	endfunction

endpackage

// ===== rtl/rde_div.sv =====
module rde_div #(
	parameter int unsigned VALUE_WIDTH = rde_pkg::VALUE_WIDTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [VALUE_WIDTH-1:0]        dividend,
	input  logic [rde_pkg::RADIX_W-1:0]   base,
	output logic                          done,
	output logic [VALUE_WIDTH-1:0]        quotient,
	output logic [rde_pkg::DIGIT_W-1:0]   remainder
);
	import rde_pkg::*;

	localparam int unsigned CNT_W = $clog2(VALUE_WIDTH + 1);

	logic [VALUE_WIDTH-1:0] quo_q;
	logic [DIGIT_W-1:0]     rem_q;
	logic [CNT_W-1:0]       cnt_q;
	logic                   done_q;
	logic [RADIX_W-1:0]     trial;
	logic                   fits;

	// Bring down the next dividend bit and test against the base
	always_comb begin
		trial = {rem_q, quo_q[VALUE_WIDTH-1]};
		fits  = (trial >= base);
	end

	// Count the steps; one quotient bit per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else if (start) begin
			cnt_q  <= CNT_W'(VALUE_WIDTH);
			done_q <= 1'b0;
		end else if (cnt_q != '0) begin
			cnt_q  <= cnt_q - CNT_W'(1);
			done_q <= (cnt_q == CNT_W'(1));
		end else begin
			done_q <= 1'b0;
		end
	end

	// Shift the quotient in, keep the partial remainder
	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
		end else if (cnt_q != '0) begin
			quo_q <= {quo_q[VALUE_WIDTH-2:0], fits};
			rem_q <= fits ? DIGIT_W'(trial - base) : trial[DIGIT_W-1:0];
		end
	end

	assign done      = done_q;
	assign quotient  = quo_q;
	assign remainder = rem_q;

endmodule

// ===== rtl/radix_digit_emitter.sv =====
// Converts each unsigned input value to ASCII digits in the base held in the radix register
// (2 to 16; smaller settings act as 2, larger as 16), least significant digit first, with
// '0'-'9' and 'A'-'F', followed by a newline transaction that carries last. Every digit
// comes from a bit-serial restoring divider that retires one quotient bit per cycle, and
// output stalls hold each finished digit until the output register is free. One value is
// converted at a time; in_ready is high only between conversions. The radix register resets
// to 10 and is written through the cfg channel, which is always ready; write it only while
// the block is idle.
module radix_digit_emitter #(
	parameter int unsigned VALUE_WIDTH = rde_pkg::VALUE_WIDTH_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [VALUE_WIDTH-1:0]       value,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [rde_pkg::CHAR_W-1:0]   character,
	output logic                         last,
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [rde_pkg::RADIX_W-1:0]  cfg_data
);
	import rde_pkg::*;

	state_t                 state_q;
	state_t                 state_d;
	logic [RADIX_W-1:0]     radix_q;
	logic [RADIX_W-1:0]     base;
	logic                   div_start;
	logic [VALUE_WIDTH-1:0] div_dividend;
	logic                   div_done;
	logic [VALUE_WIDTH-1:0] div_quotient;
	logic [DIGIT_W-1:0]     div_remainder;
	logic                   out_valid_q;
	logic [CHAR_W-1:0]      char_q;
	logic                   last_q;
	logic                   slot_free;
	logic                   out_load;
	logic [CHAR_W-1:0]      out_char;
	logic                   out_last;

	// Radix register
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radix_q <= RADIX_RESET;
		end else if (cfg_valid && cfg_ready) begin
			radix_q <= cfg_data;
		end
	end

	assign base = clamp_radix(radix_q);

	// Divider: first pass takes the input, later passes the previous quotient
	assign div_dividend = (state_q == ST_IDLE) ? value : div_quotient;

	rde_div #(
		.VALUE_WIDTH (VALUE_WIDTH)
	) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_start),
		.dividend  (div_dividend),
		.base      (base),
		.done      (div_done),
		.quotient  (div_quotient),
		.remainder (div_remainder)
	);

	assign slot_free = !out_valid_q || out_ready;
	assign in_ready  = (state_q == ST_IDLE);

	// Sequence the divisions and the emitted characters
	always_comb begin
		state_d   = state_q;
		div_start = 1'b0;
		out_load  = 1'b0;
		out_char  = digit_char(div_remainder);
		out_last  = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					div_start = 1'b1;
					state_d   = ST_DIV;
				end
			end
			ST_DIV: begin
				if (div_done) begin
					state_d = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (slot_free) begin
					out_load = 1'b1;
					if (div_quotient == '0) begin
						state_d = ST_NEWLINE;
					end else begin
						div_start = 1'b1;
						state_d   = ST_DIV;
					end
				end
			end
			ST_NEWLINE: begin
				if (slot_free) begin
					out_load = 1'b1;
					out_char = CHAR_NEWLINE;
					out_last = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Output register: load a character, drop it once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			char_q <= out_char;
			last_q <= out_last;
		end
	end

	assign out_valid = out_valid_q;
	assign character = char_q;
	assign last      = last_q;

endmodule

// ===== rtl/rde_checker.sv =====
module rde_checker #(
	parameter int unsigned VALUE_WIDTH = rde_pkg::VALUE_WIDTH_DEF
) (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         in_valid,
	input logic                         in_ready,
	input logic [VALUE_WIDTH-1:0]       value,
	input logic                         out_valid,
	input logic                         out_ready,
	input logic [rde_pkg::CHAR_W-1:0]   character,
	input logic                         last,
	input logic                         cfg_valid,
	input logic                         cfg_ready,
	input logic [rde_pkg::RADIX_W-1:0]  cfg_data
);
	import rde_pkg::*;

	// Hold a stalled result transaction
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(character) && $stable(last))
		else $error("result changed while stalled");

	// Closing transaction is the newline, every other one is a digit
	a_char_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |->
			(last ? (character == CHAR_NEWLINE) :
			((character >= CHAR_ZERO && character < CHAR_ZERO + 7'd10) ||
			(character >= CHAR_ALPHA && character < CHAR_ALPHA + 7'd6))))
		else $error("result is not a digit or closing newline");

	// Block is busy right after taking a value
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input taken during a conversion");

	// Hold a waiting input transaction
	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_ready |=> in_valid && $stable(value))
		else $error("input changed while waiting");

	// Write the radix only while nothing is in flight
	a_cfg_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid && cfg_ready |-> in_ready && !out_valid && !$isunknown(cfg_data))
		else $error("radix written during a conversion");

endmodule

bind radix_digit_emitter rde_checker #(.VALUE_WIDTH(VALUE_WIDTH)) u_rde_checker (.*);

// ===== bench/tb.sv =====
`timescale 1ns / 1ps

module tb;
	import rde_pkg::*;

	localparam int unsigned VW = VALUE_WIDTH_DEF;

	// Scoreboard: predicts the character stream of each conversion and checks it
	class conversion_scoreboard;
		typedef struct packed {
			logic [CHAR_W-1:0] ch;
			logic              lst;
		} char_item_t;

		char_item_t expected_chars[$];
		int         errors;

		function new();
			errors = 0;
		endfunction

		// Expand one accepted value into its digits and the closing newline
		function void note_value(logic [VW-1:0] v, logic [RADIX_W-1:0] r);
			int unsigned base;
			int unsigned rest;
			int unsigned d;
			char_item_t  item;
			if (r < RADIX_MIN) begin
				base = RADIX_MIN;
			end else if (r > RADIX_MAX) begin
				base = RADIX_MAX;
			end else begin
				base = r;
			end
			rest = v;
			do begin
				d = rest % base;
				rest = rest / base;
				if (d <= 9) begin
					item.ch = CHAR_ZERO + CHAR_W'(d);
				end else begin
					item.ch = CHAR_ALPHA + CHAR_W'(d - 10);
				end
				item.lst = 1'b0;
				expected_chars.push_back(item);
			end while (rest != 0);
			item.ch = CHAR_NEWLINE;
			item.lst = 1'b1;
			expected_chars.push_back(item);
		endfunction

		// Compare one output transaction against the oldest expected character
		function void check_result(logic [CHAR_W-1:0] ch, logic lst);
			char_item_t item;
			if (expected_chars.size() == 0) begin
				$display("%0t: unexpected output character=%0d last=%0b", $time, ch, lst);
				errors++;
			end else begin
				item = expected_chars.pop_front();
				if (ch !== item.ch) begin
					$display("%0t: character mismatch expected=%0d actual=%0d",
						$time, item.ch, ch);
					errors++;
				end
				if (lst !== item.lst) begin
					$display("%0t: last mismatch expected=%0b actual=%0b",
						$time, item.lst, lst);
					errors++;
				end
			end
		endfunction

		function int pending();
			return expected_chars.size();
		endfunction
	endclass

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_ready;
	logic [VW-1:0]      value;
	logic               out_valid;
	logic               out_ready;
	logic [CHAR_W-1:0]  character;
	logic               last;
	logic               cfg_valid;
	logic               cfg_ready;
	logic [RADIX_W-1:0] cfg_data;

	conversion_scoreboard sb;
	logic [RADIX_W-1:0]   radix_q;
	bit                   calm;
	int                   stall_left;

	radix_digit_emitter #(
		.VALUE_WIDTH(VW)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.value(value),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.character(character),
		.last(last),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data)
	);

	// Clock: 10 ns period
	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// Monitor all three channels at the rising edge; track the radix from reset
	always @(posedge clk) begin
		if (!arst_n) begin
			radix_q = RADIX_RESET;
		end else begin
			if (in_valid && in_ready) begin
				sb.note_value(value, radix_q);
			end
			if (out_valid && out_ready) begin
				sb.check_result(character, last);
			end
			if (cfg_valid && cfg_ready) begin
				radix_q = cfg_data;
			end
		end
	end

	// Throttle the output side with random stall bursts
	always @(negedge clk) begin
		if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			out_ready <= 1'b0;
		end else if (!calm && arst_n && $urandom_range(0, 5) == 0) begin
			stall_left <= $urandom_range(0, 6);
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
		end
	end

	// Send one value transaction, with an optional idle burst ahead of it
	task automatic send_value(input logic [VW-1:0] v);
		if (!calm && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 7)) @(negedge clk);
		end
		in_valid <= 1'b1;
		value <= v;
		do @(posedge clk); while (!in_ready);
		@(negedge clk);
	endtask

	// Hold off the input until every expected character has arrived
	task automatic wait_idle(input int settle);
		in_valid <= 1'b0;
		while (sb.pending() != 0) @(negedge clk);
		repeat (settle) @(negedge clk);
	endtask

	// Write the radix register while the block is idle
	task automatic write_radix(input logic [RADIX_W-1:0] r);
		wait_idle(4);
		cfg_valid <= 1'b1;
		cfg_data <= r;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	function automatic logic [VW-1:0] pick_value();
		int unsigned sel;
		sel = $urandom_range(0, 9);
		case (sel)
			0: return '0;
			1: return '1;
			2: return VW'($urandom_range(0, 255));
			3: return VW'(1) << $urandom_range(0, VW - 1);
			default: return VW'($urandom);
		endcase
	endfunction

	// Stimulus
	initial begin
		logic [RADIX_W-1:0] phase_radix [6];
		sb = new();
		calm = 1'b0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		value = '0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		phase_radix = '{5'd2, 5'd16, 5'd0, 5'd31, 5'd1, 5'd17};
		repeat (8) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Reset radix of ten: zero, digit boundaries, extremes
		send_value(16'd0);
		send_value(16'd1);
		send_value(16'd9);
		send_value(16'd10);
		send_value(16'hFFFF);
		send_value(16'h8000);
		send_value(16'h7FFF);
		send_value(16'd12345);

		// Hex exercises every letter digit
		write_radix(5'd16);
		send_value(16'd0);
		send_value(16'd15);
		send_value(16'hABCD);
		send_value(16'hFEDC);

		// Binary gives the longest conversions
		write_radix(5'd2);
		send_value(16'd0);
		send_value(16'd1);
		send_value(16'hFFFF);
		send_value(16'h8000);

		// Radix below two acts as binary
		write_radix(5'd0);
		send_value(16'd5);
		send_value(16'hFFFF);
		write_radix(5'd1);
		send_value(16'd3);

		// Radix above sixteen acts as hex
		write_radix(5'd31);
		send_value(16'hFEDC);
		write_radix(5'd17);
		send_value(16'd255);

		// Random phases, each under its own radix; the last one runs without idling
		for (int ph = 0; ph < 8; ph++) begin
			if (ph < 6) begin
				write_radix(phase_radix[ph]);
			end else begin
				write_radix(RADIX_W'($urandom_range(0, 31)));
			end
			if (ph == 7) begin
				calm = 1'b1;
			end
			for (int i = 0; i < 12; i++) begin
				if (!calm && $urandom_range(0, 15) == 0) begin
					wait_idle(0);
				end
				send_value(pick_value());
			end
		end

		// Drain and report
		wait_idle(40);
		if (sb.errors == 0 && sb.pending() == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

	// Watchdog
	initial begin
		#5ms;
		$display("== FAIL ==");
		$finish;
	end

endmodule
